// ----- rtl/dtba_pkg.sv -----
`default_nettype none

package dtba_pkg;

    localparam int OUT_FRAC_DEF = 24;

    // group status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    // register index taken from paddr[3]
    localparam logic REG_SCALE = 1'b0;

    typedef struct packed {
        logic signed [23:0] disp_x;
        logic signed [23:0] disp_y;
        logic signed [23:0] disp_z;
        logic               self_pair;
        logic               group_end;
    } item_t;

    typedef struct packed {
        logic [1:0]         tensor_row;
        logic [1:0]         tensor_col;
        logic signed [47:0] tensor_value;
        logic               final_elem;
        logic [1:0]         status;
        logic [47:0]        min_dist_sq;
    } result_t;

    // column-major element order: index = row + 3 * col
    function automatic logic [1:0] elem_row(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            4'd2, 4'd5, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] elem_col(input logic [3:0] k);
        logic [1:0] c;
        case (k)
            4'd0, 4'd1, 4'd2: c = 2'd0;
            4'd3, 4'd4, 4'd5: c = 2'd1;
            4'd6, 4'd7, 4'd8: c = 2'd2;
            default:          c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dipole_tensor_block_accumulator_unit.sv -----
// channel   dir   handshake                    word
// item      in    item_valid / item_ready      item_t: displacement, self_pair, group_end
// result    out   result_valid / result_ready  result_t: one tensor element
// apb       in    psel / penable / pready      scale_recip at paddr 0, 64-bit data
//
// a non-self item keeps the block busy through squares, check, normalize, square root,
// reciprocal and two powers, then per element through one 33-step divide on the shared
// restoring divider and two passes through the one multiplier, and a closing step;
// a self item goes straight to the closing step, a zero vector after squares and check;
// group_end adds the scaling of all nine sums and then the nine result words
// item_ready is high only when the sequencer is idle; result words wait in an output
// register for as long as result_ready stays low
// reset clears the sums, the status, sets the minimum to none and scale_recip to 1.0
`default_nettype none

module dipole_tensor_block_accumulator_unit
    import dtba_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire item_t       item,
    output logic             result_valid,
    input  wire logic        result_ready,
    output result_t          result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_NORM = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_W1   = 4'd5;
    localparam logic [3:0] S_W2   = 4'd6;
    localparam logic [3:0] S_W3   = 4'd7;
    localparam logic [3:0] S_NP   = 4'd8;
    localparam logic [3:0] S_DA   = 4'd9;
    localparam logic [3:0] S_TM   = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;
    localparam logic [3:0] S_SC   = 4'd12;
    localparam logic [3:0] S_EM   = 4'd13;

    localparam int SH_BASE = OUT_FRAC_BITS - 82;

    localparam logic [63:0]        LIM64      = {9'd0, {55{1'b1}}};
    localparam logic [55:0]        ACC_LIM    = {1'b0, {55{1'b1}}};
    localparam logic signed [56:0] POS57      = {2'b00, {55{1'b1}}};
    localparam logic signed [56:0] NEG57      = -POS57;
    localparam logic [56:0]        OUT_LIM57  = {10'd0, {47{1'b1}}};
    localparam logic [47:0]        LEAST_NONE = {48{1'b1}};
    localparam logic [32:0]        SCALE_ONE  = {1'b1, 32'd0};
    localparam logic [47:0]        NORM_MIN   = {2'b01, 46'd0};
    localparam logic [63:0]        SQ_BIT0    = {2'b01, 62'd0};
    localparam logic [47:0]        W1_REM0    = {18'd0, 1'b1, 29'd0};
    localparam logic [5:0]         DIV_LAST   = 6'd32;
    localparam logic [5:0]         SQRT_LAST  = 6'd31;
    localparam logic [3:0]         K_LAST     = 4'd8;

    // control
    logic [3:0]         state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [3:0]         k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [55:0] acc_reg [9];
    logic signed [55:0] acc_next [9];
    logic [1:0]         status_reg, status_next;
    logic [47:0]        least_reg, least_next;
    logic [32:0]        scale_reg, scale_next;

    // datapath
    item_t              item_reg, item_next;
    logic [47:0]        r2_reg, r2_next;
    logic [47:0]        rn_reg, rn_next;
    logic [4:0]         t_reg, t_next;
    logic [63:0]        sq_v_reg, sq_v_next;
    logic [63:0]        sq_res_reg, sq_res_next;
    logic [63:0]        sq_bit_reg, sq_bit_next;
    logic [47:0]        div_rem_reg, div_rem_next;
    logic [47:0]        div_den_reg, div_den_next;
    logic [32:0]        div_low_reg, div_low_next;
    logic [32:0]        div_q_reg, div_q_next;
    logic [31:0]        w1_reg, w1_next;
    logic [31:0]        w2_reg, w2_next;
    logic [31:0]        w3_reg, w3_next;
    logic [31:0]        a_reg, a_next;
    logic               neg_reg, neg_next;
    logic signed [55:0] term_reg, term_next;
    logic signed [67:0] mul_reg, mul_next;
    logic [64:0]        lo_reg, lo_next;
    logic signed [47:0] val_reg [9];
    logic signed [47:0] val_next [9];
    result_t            out_reg, out_next;

    function automatic logic signed [23:0] sel_x(input logic [1:0] idx, input item_t it);
        logic signed [23:0] v;
        case (idx)
            2'd0:    v = it.disp_x;
            2'd1:    v = it.disp_y;
            2'd2:    v = it.disp_z;
            default: v = it.disp_x;
        endcase
        return v;
    endfunction

    function automatic logic signed [33:0] sx34(input logic signed [23:0] v);
        return {{10{v[23]}}, v};
    endfunction

    logic [1:0]  row, col;
    logic [32:0] sc_eff;
    logic        cfg_wr;

    assign row    = elem_row(k_reg);
    assign col    = elem_col(k_reg);
    assign sc_eff = (scale_reg > SCALE_ONE) ? SCALE_ONE : scale_reg;
    assign cfg_wr = psel && penable && pwrite && (paddr[3] == REG_SCALE);

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[3] == REG_SCALE) ? {31'd0, scale_reg} : 64'd0;

    // shared multiplier operand select
    logic signed [33:0] ma, mb;
    logic [55:0]        acc_abs;

    always_comb
    begin
        acc_abs = acc_reg[k_reg][55] ? (56'd0 - acc_reg[k_reg]) : acc_reg[k_reg];
        ma = '0;
        mb = '0;
        case (state_reg)
            S_SQ:
            begin
                ma = sx34(sel_x(cnt_reg[1:0], item_reg));
                mb = sx34(sel_x(cnt_reg[1:0], item_reg));
            end
            S_W2:
            begin
                ma = {2'b00, w1_reg};
                mb = {2'b00, w1_reg};
            end
            S_W3:
            begin
                ma = {2'b00, w2_reg};
                mb = {2'b00, w1_reg};
            end
            S_NP:
            begin
                ma = sx34(sel_x(row, item_reg));
                mb = sx34(sel_x(col, item_reg));
            end
            S_TM:
            begin
                ma = {2'b00, a_reg};
                mb = {2'b00, w3_reg};
            end
            S_SC:
            begin
                if (cnt_reg == 6'd0)
                begin
                    ma = {2'b00, acc_abs[31:0]};
                end
                else
                begin
                    ma = {11'd0, acc_abs[54:32]};
                end
                mb = {1'b0, sc_eff};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        mul_next = ma * mb;
    end

    // one step of the square root
    logic [63:0] sq_try;
    logic [63:0] sq_v_step, sq_res_step;

    always_comb
    begin
        sq_try = sq_res_reg + sq_bit_reg;
        if (sq_v_reg >= sq_try)
        begin
            sq_v_step   = sq_v_reg - sq_try;
            sq_res_step = (sq_res_reg >> 1) + sq_bit_reg;
        end
        else
        begin
            sq_v_step   = sq_v_reg;
            sq_res_step = sq_res_reg >> 1;
        end
    end

    // one step of the restoring divider
    logic [48:0] rem_sh, rem_sub;
    logic        div_ge;
    logic [47:0] rem_step;
    logic [32:0] q_step;

    always_comb
    begin
        rem_sh   = {div_rem_reg, div_low_reg[32]};
        rem_sub  = rem_sh - {1'b0, div_den_reg};
        div_ge   = (rem_sh >= {1'b0, div_den_reg});
        rem_step = div_ge ? rem_sub[47:0] : rem_sh[47:0];
        q_step   = {div_q_reg[31:0], div_ge};
    end

    // term shift, rounding and clamp
    int                 sh_amt;
    logic [63:0]        mag, tm, tmp;
    logic               term_sat;
    logic signed [55:0] term_val;

    always_comb
    begin
        sh_amt   = 3 * int'(t_reg) + SH_BASE;
        mag      = mul_reg[63:0];
        term_sat = 1'b0;
        tmp      = '0;
        if (sh_amt < 0)
        begin
            if (sh_amt <= -64)
            begin
                tm = '0;
            end
            else
            begin
                // half away from zero on a magnitude
                tmp = mag >> 6'(-sh_amt - 1);
                tm  = (tmp + 64'd1) >> 1;
            end
        end
        else if (sh_amt > 0)
        begin
            if (mag > (LIM64 >> 6'(sh_amt)))
            begin
                term_sat = 1'b1;
                tm       = LIM64;
            end
            else
            begin
                tm = mag << 6'(sh_amt);
            end
        end
        else
        begin
            tm = mag;
        end
        if (tm > LIM64)
        begin
            term_sat = 1'b1;
            tm       = LIM64;
        end
        term_val = neg_reg ? (56'd0 - tm[55:0]) : tm[55:0];
    end

    // saturating accumulate
    logic signed [56:0] acc_sum;
    logic signed [55:0] acc_new;
    logic               add_sat;

    always_comb
    begin
        acc_sum = {acc_reg[k_reg][55], acc_reg[k_reg]} + {term_reg[55], term_reg};
        add_sat = 1'b0;
        if (acc_sum > POS57)
        begin
            add_sat = 1'b1;
            acc_new = ACC_LIM;
        end
        else if (acc_sum < NEG57)
        begin
            add_sat = 1'b1;
            acc_new = 56'd0 - ACC_LIM;
        end
        else
        begin
            acc_new = acc_sum[55:0];
        end
    end

    // output scaling: hi * sc + round(lo * sc / 2^32)
    logic [64:0]        rnd;
    logic [56:0]        sc_res;
    logic               sc_sat;
    logic signed [47:0] sc_val;

    always_comb
    begin
        rnd    = (lo_reg + 65'h0_8000_0000) >> 32;
        sc_res = {2'b00, mul_reg[54:0]} + rnd[56:0];
        sc_sat = 1'b0;
        if (sc_res > OUT_LIM57)
        begin
            sc_sat = 1'b1;
            sc_res = OUT_LIM57;
        end
        sc_val = acc_reg[k_reg][55] ? (48'd0 - sc_res[47:0]) : sc_res[47:0];
    end

    // sequencer
    logic               flag_sat;
    logic signed [50:0] p51, n51;
    logic [50:0]        absn;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        least_next     = least_reg;
        scale_next     = cfg_wr ? pwdata[32:0] : scale_reg;
        item_next      = item_reg;
        r2_next        = r2_reg;
        rn_next        = rn_reg;
        t_next         = t_reg;
        sq_v_next      = sq_v_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_low_next   = div_low_reg;
        div_q_next     = div_q_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        w3_next        = w3_reg;
        a_next         = a_reg;
        neg_next       = neg_reg;
        term_next      = term_reg;
        lo_next        = lo_reg;
        out_next       = out_reg;
        flag_sat       = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            acc_next[i] = acc_reg[i];
            val_next[i] = val_reg[i];
        end
        p51  = {{3{mul_reg[47]}}, mul_reg[47:0]};
        n51  = p51 + (p51 <<< 1) - ((row == col) ? {3'd0, r2_reg} : 51'd0);
        absn = n51[50] ? (51'd0 - n51) : n51;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                    r2_next   = '0;
                    cnt_next  = '0;
                    if (item.self_pair)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                if (cnt_reg != 6'd0)
                begin
                    r2_next = r2_reg + mul_reg[47:0];
                end
                if (cnt_reg == 6'd3)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_CHK:
            begin
                if (r2_reg == 48'd0)
                begin
                    status_next = STAT_ZERO;
                    state_next  = S_DONE;
                end
                else
                begin
                    if (r2_reg < least_reg)
                    begin
                        least_next = r2_reg;
                    end
                    rn_next    = r2_reg;
                    t_next     = '0;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (rn_reg < NORM_MIN)
                begin
                    rn_next = rn_reg << 2;
                    t_next  = t_reg + 5'd1;
                end
                else
                begin
                    sq_v_next   = {rn_reg, 16'd0};
                    sq_res_next = '0;
                    sq_bit_next = SQ_BIT0;
                    cnt_next    = '0;
                    state_next  = S_SQRT;
                end
            end
            S_SQRT:
            begin
                sq_v_next   = sq_v_step;
                sq_res_next = sq_res_step;
                sq_bit_next = sq_bit_reg >> 2;
                if (cnt_reg == SQRT_LAST)
                begin
                    // w1 = 2^62 / P
                    div_rem_next = W1_REM0;
                    div_den_next = {16'd0, sq_res_step[31:0]};
                    div_low_next = '0;
                    div_q_next   = '0;
                    cnt_next     = '0;
                    state_next   = S_W1;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_W1:
            begin
                div_rem_next = rem_step;
                div_low_next = {div_low_reg[31:0], 1'b0};
                div_q_next   = q_step;
                if (cnt_reg == DIV_LAST)
                begin
                    w1_next    = q_step[31:0];
                    cnt_next   = '0;
                    state_next = S_W2;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_W2:
            begin
                if (cnt_reg == 6'd0)
                begin
                    cnt_next = 6'd1;
                end
                else
                begin
                    w2_next    = mul_reg[62:31];
                    cnt_next   = '0;
                    state_next = S_W3;
                end
            end
            S_W3:
            begin
                if (cnt_reg == 6'd0)
                begin
                    cnt_next = 6'd1;
                end
                else
                begin
                    w3_next    = mul_reg[62:31];
                    cnt_next   = '0;
                    k_next     = '0;
                    state_next = S_NP;
                end
            end
            S_NP:
            begin
                if (cnt_reg == 6'd0)
                begin
                    cnt_next = 6'd1;
                end
                else
                begin
                    // |N| * 2^30 / R with the top of the numerator preloaded
                    neg_next     = n51[50];
                    div_rem_next = {1'b0, absn[49:3]};
                    div_low_next = {absn[2:0], 30'd0};
                    div_den_next = r2_reg;
                    div_q_next   = '0;
                    cnt_next     = '0;
                    state_next   = S_DA;
                end
            end
            S_DA:
            begin
                div_rem_next = rem_step;
                div_low_next = {div_low_reg[31:0], 1'b0};
                div_q_next   = q_step;
                if (cnt_reg == DIV_LAST)
                begin
                    a_next     = q_step[31:0];
                    cnt_next   = '0;
                    state_next = S_TM;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_TM:
            begin
                if (cnt_reg == 6'd0)
                begin
                    cnt_next = 6'd1;
                end
                else if (cnt_reg == 6'd1)
                begin
                    term_next = term_val;
                    flag_sat  = term_sat;
                    cnt_next  = 6'd2;
                end
                else
                begin
                    acc_next[k_reg] = acc_new;
                    flag_sat        = add_sat;
                    cnt_next        = '0;
                    if (k_reg == K_LAST)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        state_next = S_NP;
                    end
                end
            end
            S_DONE:
            begin
                cnt_next = '0;
                k_next   = '0;
                if (item_reg.group_end)
                begin
                    state_next = S_SC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SC:
            begin
                if (cnt_reg == 6'd0)
                begin
                    cnt_next = 6'd1;
                end
                else if (cnt_reg == 6'd1)
                begin
                    lo_next  = mul_reg[64:0];
                    cnt_next = 6'd2;
                end
                else
                begin
                    val_next[k_reg] = sc_val;
                    flag_sat        = sc_sat;
                    cnt_next        = '0;
                    if (k_reg == K_LAST)
                    begin
                        k_next         = '0;
                        out_valid_next = 1'b0;
                        state_next     = S_EM;
                    end
                    else
                    begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            S_EM:
            begin
                if (!out_valid_reg)
                begin
                    out_next.tensor_row   = row;
                    out_next.tensor_col   = col;
                    out_next.tensor_value = val_reg[k_reg];
                    out_next.final_elem   = (k_reg == K_LAST);
                    out_next.status       = status_reg;
                    out_next.min_dist_sq  = (least_reg == LEAST_NONE) ? 48'd0 : least_reg;
                    out_valid_next        = 1'b1;
                end
                else if (result_ready)
                begin
                    out_valid_next = 1'b0;
                    if (k_reg == K_LAST)
                    begin
                        for (int i = 0; i < 9; i++)
                        begin
                            acc_next[i] = '0;
                        end
                        status_next = STAT_OK;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // zero-distance error wins over saturation
        if (flag_sat && (status_next == STAT_OK))
        begin
            status_next = STAT_SAT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STAT_OK;
            least_reg     <= LEAST_NONE;
            scale_reg     <= SCALE_ONE;
            for (int i = 0; i < 9; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            least_reg     <= least_next;
            scale_reg     <= scale_next;
            for (int i = 0; i < 9; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        r2_reg      <= r2_next;
        rn_reg      <= rn_next;
        t_reg       <= t_next;
        sq_v_reg    <= sq_v_next;
        sq_res_reg  <= sq_res_next;
        sq_bit_reg  <= sq_bit_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_low_reg <= div_low_next;
        div_q_reg   <= div_q_next;
        w1_reg      <= w1_next;
        w2_reg      <= w2_next;
        w3_reg      <= w3_next;
        a_reg       <= a_next;
        neg_reg     <= neg_next;
        term_reg    <= term_next;
        mul_reg     <= mul_next;
        lo_reg      <= lo_next;
        out_reg     <= out_next;
        for (int i = 0; i < 9; i++)
        begin
            val_reg[i] <= val_next[i];
        end
    end

endmodule

`default_nettype wire
